// ===== hdl/lru_pr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lru_pr_pkg;

	localparam int FRAMES    = 16;
	localparam int PAGE_BITS = 16;
	localparam int IDX_W     = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int CNT_W     = $clog2(FRAMES + 1);
	localparam int RANK_W    = IDX_W;
	localparam int CFG_W     = 5;
	localparam int FAULT_W   = 32;
	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_CHOOSE,
		ST_SCAN,
		ST_COMMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic lookup;
		logic scan_start;
		logic scan_step;
		logic commit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic resolved;
		logic scan_done;
	} ctrl_sts_t;

endpackage

`default_nettype wire

// ===== hdl/lru_pr_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lru_pr_ctrl import lru_pr_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_stall,
	output logic           out_valid,
	input  wire logic      out_stall,
	output logic           cfg_ready,
	input  wire ctrl_sts_t sts,
	output ctrl_cmd_t      cmd
);

	state_t state_q, state_nxt;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE:   if (in_valid) state_nxt = ST_LOOKUP;
			ST_LOOKUP: state_nxt = ST_CHOOSE;
			ST_CHOOSE: state_nxt = sts.resolved ? ST_COMMIT : ST_SCAN;
			ST_SCAN:   if (sts.scan_done) state_nxt = ST_COMMIT;
			ST_COMMIT: if (out_free) state_nxt = ST_IDLE;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		in_stall  = 1'b1;
		cfg_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall  = 1'b0;
				cfg_ready = 1'b1;
				cmd.load  = in_valid;
			end
			ST_LOOKUP: cmd.lookup = 1'b1;
			ST_CHOOSE: cmd.scan_start = !sts.resolved;
			ST_SCAN:   cmd.scan_step = !sts.scan_done;
			ST_COMMIT: cmd.commit = out_free;
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_nxt;
			out_valid_q <= cmd.commit || (out_valid_q && out_stall);
		end
	end

`ifndef NO_ASSERTIONS
	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid_q)
		else $error("result not presented after commit");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !(out_valid_q && out_stall))
		else $error("commit over a stalled result");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> out_valid_q)
		else $error("stalled result dropped");
`endif

endmodule

`default_nettype wire

// ===== hdl/lru_pr_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lru_pr_dp import lru_pr_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire ctrl_cmd_t            cmd,
	output ctrl_sts_t                 sts,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic [15:0]          page_number,
	output logic                      hit,
	output logic [IDX_W-1:0]          frame_index,
	output logic                      evicted_valid,
	output logic [15:0]               evicted_page,
	output logic [FAULT_W-1:0]        fault_total
);

	logic [CFG_W-1:0]     fiu_q;
	logic [FRAMES-1:0]    valid_q;
	logic [PAGE_BITS-1:0] page_q [FRAMES];
	logic [RANK_W-1:0]    rank_q [FRAMES];
	logic [FAULT_W-1:0]   fault_q;

	logic [PAGE_BITS-1:0] cur_q;
	logic                 lk_hit_q, lk_free_q;
	logic [IDX_W-1:0]     hit_idx_q, free_idx_q;
	logic [CNT_W-1:0]     k_q;
	logic [IDX_W-1:0]     best_q;

	logic [CNT_W-1:0]     n_act;
	logic [FRAMES-1:0]    active;
	logic                 lk_hit, lk_free;
	logic [IDX_W-1:0]     hit_idx, free_idx;
	logic [IDX_W-1:0]     sel;
	logic                 miss, evict;
	logic                 was_valid;
	logic [RANK_W-1:0]    old_rank;
	logic [FAULT_W-1:0]   fault_nxt;
	logic [IDX_W-1:0]     k_idx;

	always_comb begin
		if (fiu_q == '0)
			n_act = CNT_W'(1);
		else if (CNT_W'(fiu_q) > CNT_W'(FRAMES))
			n_act = CNT_W'(FRAMES);
		else
			n_act = CNT_W'(fiu_q);
		for (int k = 0; k < FRAMES; k++)
			active[k] = CNT_W'(k) < n_act;
	end

	always_comb begin
		lk_hit   = 1'b0;
		lk_free  = 1'b0;
		hit_idx  = '0;
		free_idx = '0;
		for (int k = FRAMES - 1; k >= 0; k--) begin
			if (active[k] && valid_q[k] && page_q[k] == cur_q) begin
				lk_hit  = 1'b1;
				hit_idx = IDX_W'(k);
			end
			if (active[k] && !valid_q[k]) begin
				lk_free  = 1'b1;
				free_idx = IDX_W'(k);
			end
		end
	end

	assign k_idx         = k_q[IDX_W-1:0];
	assign sts.resolved  = lk_hit_q || lk_free_q;
	assign sts.scan_done = k_q >= n_act;

	assign miss      = !lk_hit_q;
	assign evict     = !lk_hit_q && !lk_free_q;
	assign sel       = lk_hit_q ? hit_idx_q : (lk_free_q ? free_idx_q : best_q);
	assign was_valid = valid_q[sel];
	assign old_rank  = rank_q[sel];
	assign fault_nxt = (miss && fault_q != '1) ? fault_q + FAULT_W'(1) : fault_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fiu_q   <= CFG_RESET;
			valid_q <= '0;
			fault_q <= '0;
		end else begin
			if (cfg_we)
				fiu_q <= cfg_data;
			if (cmd.commit) begin
				valid_q[sel] <= 1'b1;
				fault_q      <= fault_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load)
			cur_q <= page_number[PAGE_BITS-1:0];
		if (cmd.lookup) begin
			lk_hit_q   <= lk_hit;
			lk_free_q  <= lk_free;
			hit_idx_q  <= hit_idx;
			free_idx_q <= free_idx;
		end
		if (cmd.scan_start) begin
			best_q <= '0;
			k_q    <= CNT_W'(1);
		end else if (cmd.scan_step) begin
			if (rank_q[k_idx] > rank_q[best_q])
				best_q <= k_idx;
			k_q <= k_q + CNT_W'(1);
		end
		if (cmd.commit) begin
			for (int k = 0; k < FRAMES; k++) begin
				if (IDX_W'(k) != sel && valid_q[k] && (!was_valid || rank_q[k] < old_rank))
					rank_q[k] <= rank_q[k] + RANK_W'(1);
			end
			rank_q[sel] <= '0;
			if (miss)
				page_q[sel] <= cur_q;
			hit           <= lk_hit_q;
			frame_index   <= sel;
			evicted_valid <= evict;
			evicted_page  <= evict ? 16'(page_q[sel]) : 16'd0;
			fault_total   <= fault_nxt;
		end
	end

`ifndef NO_ASSERTIONS
	a_scan_needs_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_step |-> !lk_hit_q && !lk_free_q)
		else $error("victim scan with a hit or free frame");

	a_touch_mru: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> valid_q[frame_index] && rank_q[frame_index] == '0)
		else $error("used frame not most recent");

	a_victim_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && evict |-> valid_q[best_q] && active[best_q])
		else $error("victim not a resident active frame");

	a_fault_counted: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && miss |=> fault_q != '0)
		else $error("fault not counted");
`endif

endmodule

`default_nettype wire

// ===== hdl/lru_page_replacement.sv =====
`timescale 1ns / 1ps
`default_nettype none

// LRU page replacement over 16 frames. Each transaction on the input takes one
// page reference and yields one result: hit, frame used, evicted page and the
// saturating fault total. A reference passes the lookup, choose and commit states
// on a hit or on a fill of a free frame; when a resident page must be evicted, a
// victim scan between choose and commit compares one frame's rank per cycle over
// the frames in use (clamped to 1..16). A finished result sits in the output
// register, so the next reference is taken while it waits; that reference holds
// in its final cycle until the waiting result is taken. frames_in_use is written
// only while no reference is in flight.

module lru_page_replacement import lru_pr_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [15:0]       page_number,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic                   hit,
	output logic [IDX_W-1:0]       frame_index,
	output logic                   evicted_valid,
	output logic [15:0]            evicted_page,
	output logic [FAULT_W-1:0]     fault_total,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [CFG_W-1:0]  frames_in_use
);

	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	lru_pr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cfg_ready (cfg_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	lru_pr_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_data      (frames_in_use),
		.page_number   (page_number),
		.hit           (hit),
		.frame_index   (frame_index),
		.evicted_valid (evicted_valid),
		.evicted_page  (evicted_page),
		.fault_total   (fault_total)
	);

endmodule

`default_nettype wire

// ===== tb/tb_lru_page_replacement.sv =====
`timescale 1ns / 1ps

module tb_lru_page_replacement;
	import lru_pr_pkg::*;

	typedef struct packed {
		logic               hit;
		logic [IDX_W-1:0]   frame;
		logic               ev_valid;
		logic [15:0]        ev_page;
		logic [FAULT_W-1:0] faults;
	} lru_result_t;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 4 + FRAMES + 8;
	localparam int PHASE_ITEMS    = 118;

	logic               clk           = 1'b0;
	logic               arst_n        = 1'b0;
	logic               in_valid      = 1'b0;
	logic               in_stall;
	logic [15:0]        page_number   = '0;
	logic               out_valid;
	logic               out_stall     = 1'b0;
	logic               hit;
	logic [IDX_W-1:0]   frame_index;
	logic               evicted_valid;
	logic [15:0]        evicted_page;
	logic [FAULT_W-1:0] fault_total;
	logic               cfg_valid     = 1'b0;
	logic               cfg_ready;
	logic [CFG_W-1:0]   frames_in_use = CFG_RESET;

	// predictor state
	logic [CFG_W-1:0]   model_frames = CFG_RESET;
	logic               frame_live [FRAMES];
	logic [15:0]        frame_tag  [FRAMES];
	logic [RANK_W-1:0]  frame_age  [FRAMES];
	logic [FAULT_W-1:0] fault_sum;

	logic [15:0]  page_refs [$];
	lru_result_t  expected_results [$];
	lru_result_t  want;

	bit calm = 1'b0;
	int in_idle_pct = 0;
	int out_stall_pct = 0;
	int in_gap = 0;
	int stall_left = 0;
	int idle_cycles = 0;
	int errors = 0;
	int checked = 0;
	int hits_seen = 0;
	int fills_seen = 0;
	int evictions_seen = 0;
	int settings_seen = 0;

	lru_page_replacement dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.page_number  (page_number),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.hit          (hit),
		.frame_index  (frame_index),
		.evicted_valid(evicted_valid),
		.evicted_page (evicted_page),
		.fault_total  (fault_total),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.frames_in_use(frames_in_use)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int active_count();
		int n;
		n = int'(model_frames);
		if (n < 1) n = 1;
		if (n > FRAMES) n = FRAMES;
		return n;
	endfunction

	function automatic lru_result_t lru_predict(input logic [15:0] pg);
		lru_result_t r;
		int n, k, f;
		bit found, was_live;
		logic [RANK_W-1:0] old;
		n = active_count();
		r = '0;
		f = 0;
		found = 1'b0;
		for (k = 0; k < n; k++) begin
			if (!found && frame_live[k] && frame_tag[k] == pg) begin
				f = k;
				found = 1'b1;
			end
		end
		r.hit = found;
		if (!found) begin
			for (k = 0; k < n; k++) begin
				if (!found && !frame_live[k]) begin
					f = k;
					found = 1'b1;
				end
			end
			if (!found) begin
				f = 0;
				for (k = 1; k < n; k++)
					if (frame_age[k] > frame_age[f]) f = k;
				r.ev_valid = 1'b1;
				r.ev_page = frame_tag[f];
			end
			frame_tag[f] = pg;
			if (fault_sum != '1) fault_sum = fault_sum + FAULT_W'(1);
		end
		// move frame f to most recent
		was_live = frame_live[f];
		old = frame_age[f];
		for (k = 0; k < FRAMES; k++) begin
			if (k != f && frame_live[k] && (!was_live || frame_age[k] < old))
				frame_age[k] = frame_age[k] + RANK_W'(1);
		end
		frame_age[f] = '0;
		frame_live[f] = 1'b1;
		r.frame = IDX_W'(f);
		r.faults = fault_sum;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] exp_val);
		errors++;
		if (errors <= 100)
			$display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got,
				exp_val);
	endtask

	// sample after the edge has fully settled
	task automatic wait_drained();
		do begin
			@(posedge clk);
			#1;
		end while (page_refs.size() != 0 || in_valid || expected_results.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_frames(input logic [CFG_W-1:0] value);
		wait_drained();
		cfg_valid <= 1'b1;
		frames_in_use <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		model_frames = value;
		settings_seen++;
	endtask

	task automatic queue_random(input int count);
		logic [15:0] pool [32];
		logic [15:0] pg;
		int span, i;
		span = active_count() + $urandom_range(active_count() + 4, 0);
		if (span > 32) span = 32;
		for (i = 0; i < 32; i++) pool[i] = 16'($urandom);
		pg = pool[0];
		for (i = 0; i < count; i++) begin
			case ($urandom_range(9))
				0: pg = 16'($urandom);
				1, 2: ;
				default: pg = pool[$urandom_range(span - 1, 0)];
			endcase
			page_refs.push_back(pg);
		end
	endtask

	// input driver
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				expected_results.push_back(lru_predict(page_number));
			if (!in_valid || !in_stall) begin
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (page_refs.size() > 0) begin
					in_valid <= 1'b1;
					page_number <= page_refs.pop_front();
					if (!calm && $urandom_range(99) < in_idle_pct)
						in_gap = $urandom_range(8, 1);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result with none pending", fault_total, 0);
				end else begin
					want = expected_results.pop_front();
					if (hit !== want.hit) report_mismatch("hit", 32'(hit), 32'(want.hit));
					if (frame_index !== want.frame)
						report_mismatch("frame_index", 32'(frame_index), 32'(want.frame));
					if (evicted_valid !== want.ev_valid)
						report_mismatch("evicted_valid", 32'(evicted_valid),
							32'(want.ev_valid));
					if (evicted_page !== want.ev_page)
						report_mismatch("evicted_page", 32'(evicted_page), 32'(want.ev_page));
					if (fault_total !== want.faults)
						report_mismatch("fault_total", fault_total, want.faults);
					checked++;
					if (want.hit) hits_seen++;
					else if (want.ev_valid) evictions_seen++;
					else fills_seen++;
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (!calm && $urandom_range(99) < out_stall_pct) begin
				stall_left = $urandom_range(7, 0);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// watchdog on cycles with no transaction anywhere
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: watchdog expired, %0d results pending", $realtime,
					expected_results.size());
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		logic [CFG_W-1:0] settings [11];
		int ph, k;
		int pcts [3];
		settings = '{5'd16, 5'd1, 5'd2, 5'd4, 5'd8, 5'd31, 5'd0, 5'd3, 5'd16, 5'd5, 5'd16};
		pcts = '{0, 15, 50};
		for (k = 0; k < FRAMES; k++) begin
			frame_live[k] = 1'b0;
			frame_tag[k] = '0;
			frame_age[k] = '0;
		end
		fault_sum = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, hits, fills, out-of-range frame counts, leftover frames
		in_idle_pct = 30;
		out_stall_pct = 30;
		page_refs = '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF};
		write_frames(5'd0);
		page_refs = '{16'h1234, 16'h1234, 16'hFFFF, 16'hFFFF, 16'h0001};
		write_frames(5'd3);
		page_refs = '{16'h8000, 16'h4000, 16'h8000, 16'h2000, 16'h0001};
		write_frames(5'd31);
		page_refs = '{16'h00FF, 16'hFF00, 16'h8000, 16'h5555, 16'hAAAA};

		for (ph = 0; ph < 11; ph++) begin
			write_frames(settings[ph]);
			if (ph == 10) begin
				calm = 1'b1;
			end else begin
				in_idle_pct = pcts[$urandom_range(2)];
				out_stall_pct = pcts[$urandom_range(2)];
			end
			queue_random(PHASE_ITEMS);
		end

		wait_drained();
		$display("Checked %0d results over %0d frame-count settings", checked, settings_seen);
		$display("  %0d hits, %0d free-frame fills, %0d evictions", hits_seen, fills_seen,
			evictions_seen);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/lru_pr_pkg.sv
hdl/lru_pr_ctrl.sv
hdl/lru_pr_dp.sv
hdl/lru_page_replacement.sv
tb/tb_lru_page_replacement.sv
